FILE: src/nfgd_pkg.sv
// Package: shared constants for the near-field geometric delay block.
package nfgd_pkg;

    // Default coordinate width (two's complement millimetres).
    localparam int COORD_BITS_DEF = 30;

    // Width of the delay result in picoseconds.
    localparam int DELAY_BITS = 34;

    // Picoseconds per millimetre in Q16: round(65536 * 1e9 / 2.99795e8).
    localparam int PS_PER_MM_Q16 = 218603;

    // Fraction bits of the scale factor.
    localparam int Q_SHIFT = 16;

endpackage

FILE: src/near_field_geometric_delay_top.sv
// Top level: near-field geometric delay, one antenna/sky-point pair per request.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | sink      | in_valid / in_stall | sky_x sky_y sky_z ant_x ant_y ant_z
//  out     | source    | out_valid/out_stall | delay_ps
//
// One request enters per cycle when in_stall is low; results leave in order. The
// square-root pipeline in the middle produces one root bit per stage.
// Reset clears the valid bits only; there is no clearing pass.
// in_stall comes from a register: it rises when the skid stage holds a result while
// the output register is stalled, and the whole pipeline then freezes in place.
module near_field_geometric_delay_top
    import nfgd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] sky_x,
    input  logic signed [COORD_BITS-1:0] sky_y,
    input  logic signed [COORD_BITS-1:0] sky_z,
    input  logic signed [COORD_BITS-1:0] ant_x,
    input  logic signed [COORD_BITS-1:0] ant_y,
    input  logic signed [COORD_BITS-1:0] ant_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DELAY_BITS-1:0] delay_ps
);

    // Widths: a coordinate difference needs one more bit; |diff| <= 2^COORD_BITS,
    // so a sum of three squares stays below 2^(2*COORD_BITS+2).
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int D_W    = ROOT_W + 1;
    // Product must cover Q_SHIFT + DELAY_BITS bits so the result slice sees the sign.
    localparam int PROD_W = (D_W + 19 > DELAY_BITS + Q_SHIFT) ? D_W + 19
                                                             : DELAY_BITS + Q_SHIFT;
    // 5 front stages, square root, difference, multiply, round.
    localparam int NSTAGE = 5 + ROOT_W + 3;

    localparam logic signed [PROD_W-1:0] SCALE = PROD_W'(PS_PER_MM_Q16);
    localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(1) <<< (Q_SHIFT - 1);

    // ---------------------------------------------------------------- control
    logic              en;
    logic [NSTAGE-1:0] valid_pipe_reg;
    logic              last_valid;
    logic              take;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    assign en         = !skid_valid_reg;
    assign last_valid = valid_pipe_reg[NSTAGE-1];
    assign take       = !out_valid_reg || !out_stall;
    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_pipe_reg <= {valid_pipe_reg[NSTAGE-2:0], in_valid};
            end
            if (skid_valid_reg)
            begin
                if (take)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (take)
            begin
                out_valid_reg <= last_valid;
            end
            else if (last_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    // Stage 1: differences, sky coordinates widened.
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] sky_reg  [3];
    // Stage 2: magnitudes.
    logic [DIFF_W-1:0] mag_d_reg [3];
    logic [DIFF_W-1:0] mag_s_reg [3];
    // Stage 3: squares.
    logic [SQ_W-1:0] sq_d_reg [3];
    logic [SQ_W-1:0] sq_s_reg [3];
    // Stage 4/5: sums.
    logic [SQ_W-1:0] part_d_reg, part_s_reg, last_d_reg, last_s_reg;
    logic [SQ_W-1:0] sum_d_reg, sum_s_reg;
    // After the roots.
    logic [ROOT_W-1:0]        root_d, root_s;
    logic signed [D_W-1:0]    dist_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rounded;
    logic [DELAY_BITS-1:0]    rnd_reg;
    logic [DELAY_BITS-1:0]    skid_reg;
    logic [DELAY_BITS-1:0]    out_reg;

    logic signed [DIFF_W-1:0] sky_ext [3];
    logic signed [DIFF_W-1:0] ant_ext [3];

    assign sky_ext[0] = DIFF_W'(sky_x);
    assign sky_ext[1] = DIFF_W'(sky_y);
    assign sky_ext[2] = DIFF_W'(sky_z);
    assign ant_ext[0] = DIFF_W'(ant_x);
    assign ant_ext[1] = DIFF_W'(ant_y);
    assign ant_ext[2] = DIFF_W'(ant_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i]  <= sky_ext[i] - ant_ext[i];
                sky_reg[i]   <= sky_ext[i];
                // Two's complement negate; the most negative difference gives 2^COORD_BITS - 1.
                mag_d_reg[i] <= diff_reg[i][DIFF_W-1] ? (~diff_reg[i] + 1'b1) : diff_reg[i];
                mag_s_reg[i] <= sky_reg[i][DIFF_W-1] ? (~sky_reg[i] + 1'b1) : sky_reg[i];
                sq_d_reg[i]  <= SQ_W'(mag_d_reg[i]) * SQ_W'(mag_d_reg[i]);
                sq_s_reg[i]  <= SQ_W'(mag_s_reg[i]) * SQ_W'(mag_s_reg[i]);
            end
            part_d_reg <= sq_d_reg[0] + sq_d_reg[1];
            part_s_reg <= sq_s_reg[0] + sq_s_reg[1];
            last_d_reg <= sq_d_reg[2];
            last_s_reg <= sq_s_reg[2];
            sum_d_reg  <= part_d_reg + last_d_reg;
            sum_s_reg  <= part_s_reg + last_s_reg;
            dist_reg   <= $signed({1'b0, root_d}) - $signed({1'b0, root_s});
            prod_reg   <= PROD_W'(dist_reg) * SCALE;
            rnd_reg    <= rounded[Q_SHIFT +: DELAY_BITS];
        end
    end

    // Add one half, then the slice is the arithmetic shift (ties go up).
    assign rounded = prod_reg + HALF;

    nfgd_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt_diff (
        .clk      (clk),
        .en       (en),
        .radicand (sum_d_reg),
        .root     (root_d)
    );

    nfgd_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_sqrt_sky (
        .clk      (clk),
        .en       (en),
        .radicand (sum_s_reg),
        .root     (root_s)
    );

    // Output register plus one skid entry.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (take)
        begin
            out_reg <= rnd_reg;
        end
        else
        begin
            skid_reg <= rnd_reg;
        end
    end

    assign delay_ps = out_reg;

    // ---------------------------------------------------------------- checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_pipe_reg))
        else $error("pipeline moved while frozen");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en && last_valid && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("result dropped under output stall");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !(out_valid_reg && out_stall) |=> !skid_valid_reg && out_valid_reg)
        else $error("skid failed to drain");

endmodule

FILE: src/nfgd_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
module nfgd_isqrt #(
    parameter int ROOT_W = 31
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic [ROOT_W-1:0]     root
);

    localparam int IN_W = 2 * ROOT_W;

    // Stage s writes entry s+1; the remainder and radicand are not kept past the last stage.
    logic [ROOT_W-1:0] rem_pipe  [1:ROOT_W-1];
    logic [ROOT_W-1:0] root_pipe [1:ROOT_W];
    logic [IN_W-1:0]   rad_pipe  [1:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [IN_W-1:0]   rad_in;
        logic [ROOT_W+1:0] shifted;
        logic [ROOT_W+1:0] trial;
        logic              fits;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_mid
            assign rem_in  = rem_pipe[s];
            assign root_in = root_pipe[s];
            assign rad_in  = rad_pipe[s];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign shifted = {rem_in, rad_in[IN_W-1-2*s -: 2]};
        assign trial   = {root_in, 2'b01};
        assign fits    = (shifted >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_pipe[s+1] <= {root_in[ROOT_W-2:0], fits};
            end
        end

        if (s < ROOT_W - 1) begin : g_fwd
            logic [ROOT_W+1:0] diff;

            assign diff = shifted - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_pipe[s+1] <= fits ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
                    rad_pipe[s+1] <= rad_in;
                end
            end
        end
    end

    assign root = root_pipe[ROOT_W];

endmodule

FILE: sim/near_field_geometric_delay_top_tb.sv
// Testbench for near_field_geometric_delay_top: directed table plus random requests.
`timescale 1ns / 1ps

module near_field_geometric_delay_top_tb;
    import nfgd_pkg::*;

    localparam int COORD_BITS = COORD_BITS_DEF;
    localparam int NUM_DIRECTED = 22;
    localparam int NUM_RANDOM = 1000;

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // one antenna / sky-point pair
    typedef struct {
        logic signed [COORD_BITS-1:0] sx, sy, sz;
        logic signed [COORD_BITS-1:0] ax, ay, az;
    } pair_t;

    // directed row: delay is only trusted when known is set
    typedef struct {
        pair_t                        pair;
        bit                           known;
        logic signed [DELAY_BITS-1:0] delay;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] sky_x, sky_y, sky_z;
    logic signed [COORD_BITS-1:0] ant_x, ant_y, ant_z;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [DELAY_BITS-1:0] delay_ps;

    logic signed [DELAY_BITS-1:0] pending_delays[$];
    dir_row_t                     dir_rows[NUM_DIRECTED];
    int                           mismatch_count = 0;
    bit                           gaps_on = 1'b1;
    logic                         stall_on;

    near_field_geometric_delay_top #(.COORD_BITS(COORD_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sky_x     (sky_x),
        .sky_y     (sky_y),
        .sky_z     (sky_z),
        .ant_x     (ant_x),
        .ant_y     (ant_y),
        .ant_z     (ant_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .delay_ps  (delay_ps)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Digit-by-digit floor square root on 64 bits.
    function automatic bit [63:0] floor_sqrt64(input bit [63:0] v);
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] probe;
        rem   = v;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // (|S - A| - |S|) in mm, scaled to ps with round-half-up.
    function automatic logic signed [DELAY_BITS-1:0] geometric_delay_ps(input pair_t p);
        longint    dx, dy, dz;
        longint    sx, sy, sz;
        bit [63:0] path_sq, sky_sq;
        longint    d_mm, scaled;
        sx = longint'(p.sx);
        sy = longint'(p.sy);
        sz = longint'(p.sz);
        dx = sx - longint'(p.ax);
        dy = sy - longint'(p.ay);
        dz = sz - longint'(p.az);
        path_sq = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
        sky_sq  = 64'(sx * sx) + 64'(sy * sy) + 64'(sz * sz);
        d_mm    = longint'(floor_sqrt64(path_sq)) - longint'(floor_sqrt64(sky_sq));
        scaled  = d_mm * longint'(PS_PER_MM_Q16) + (longint'(1) << (Q_SHIFT - 1));
        return DELAY_BITS'(scaled >>> Q_SHIFT);
    endfunction

    // mostly full range, with extremes and small/moderate values mixed in
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return COORD_BITS'($urandom_range(0, 128)) - COORD_BITS'(64);
            3, 4:    return COORD_BITS'($urandom_range(0, 200000)) - COORD_BITS'(100000);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one request, hold it until accepted, then log its expected delay.
    task automatic push_request(input pair_t p, input bit known,
                                input logic signed [DELAY_BITS-1:0] typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sky_x    <= p.sx;
        sky_y    <= p.sy;
        sky_z    <= p.sz;
        ant_x    <= p.ax;
        ant_y    <= p.ay;
        ant_z    <= p.az;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_delays.push_back(known ? typed : geometric_delay_ps(p));
    endtask

    // Sender holds off until every outstanding result is back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_delays.size() != 0);
    endtask

    // Output stall: short bursts mostly, an occasional long hold; off when stall_on is low.
    initial
    begin
        int r;
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (!stall_on || r < 70)
                    out_stall <= 1'b0;
                else if (r < 95)
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(10, 60);
                end
            end
        end
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        logic signed [DELAY_BITS-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_delays.size() == 0)
            begin
                $error("delay_ps: no request outstanding, got %0d", delay_ps);
                mismatch_count++;
            end
            else
            begin
                want = pending_delays.pop_front();
                if (delay_ps !== want)
                begin
                    $error("delay_ps: expected %0d, got %0d", want, delay_ps);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        pair_t p;
        int    mode;
        in_valid = 1'b0;
        sky_x    = '0;
        sky_y    = '0;
        sky_z    = '0;
        ant_x    = '0;
        ant_y    = '0;
        ant_z    = '0;
        stall_on = 1'b1;
        rst_n    = 1'b0;

        // sky xyz, antenna xyz, known, delay
        dir_rows[0]  = '{'{0, 0, 0, 0, 0, 0}, 1'b1, 0};
        dir_rows[1]  = '{'{0, 0, 0, 1, 0, 0}, 1'b1, 3};           // sky at origin
        dir_rows[2]  = '{'{0, 0, 0, -1, 0, 0}, 1'b1, 3};
        dir_rows[3]  = '{'{0, 0, 0, 3, 4, 0}, 1'b1, 17};
        dir_rows[4]  = '{'{0, 0, 0, 1, 1, 0}, 1'b1, 3};           // root floors
        dir_rows[5]  = '{'{0, 0, 2, 0, 0, 1}, 1'b1, -3};          // negative rounding
        dir_rows[6]  = '{'{0, 0, 2, 0, 0, 2}, 1'b1, -7};
        dir_rows[7]  = '{'{0, 0, 0, 32768, 0, 0}, 1'b1, 109302};  // exact half rounds up
        dir_rows[8]  = '{'{0, 0, 32768, 0, 0, 32768}, 1'b1, -109301};
        dir_rows[9]  = '{'{1000, 0, 0, 0, 0, 0}, 1'b1, 0};
        dir_rows[10] = '{'{C_MIN, C_MIN, C_MIN, 0, 0, 0}, 1'b1, 0};
        dir_rows[11] = '{'{C_MAX, C_MAX, C_MAX, 0, 0, 0}, 1'b1, 0};
        dir_rows[12] = '{'{0, 0, 0, C_MAX, 0, 0}, 1'b0, 0};
        dir_rows[13] = '{'{0, 0, 0, C_MAX, C_MAX, C_MAX}, 1'b0, 0};
        dir_rows[14] = '{'{0, 0, 0, C_MIN, C_MIN, C_MIN}, 1'b0, 0};
        dir_rows[15] = '{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX}, 1'b0, 0};
        dir_rows[16] = '{'{C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN}, 1'b0, 0};
        dir_rows[17] = '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}, 1'b0, 0};
        dir_rows[18] = '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}, 1'b0, 0};
        dir_rows[19] = '{'{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN}, 1'b0, 0};
        dir_rows[20] = '{'{30'sh2AAAAAAA, 30'sh15555555, 30'sh2AAAAAAA,
                           30'sh15555555, 30'sh2AAAAAAA, 30'sh15555555}, 1'b0, 0};
        dir_rows[21] = '{'{30'sh15555555, 30'sh2AAAAAAA, 30'sh15555555,
                           30'sh2AAAAAAA, 30'sh15555555, 30'sh2AAAAAAA}, 1'b0, 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            push_request(dir_rows[i].pair, dir_rows[i].known, dir_rows[i].delay);
        wait_drained();

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // switch idling on/off in stretches so some runs go back to back
            if (i % 100 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stall_on <= ($urandom_range(0, 3) != 0);
            end
            if (i == NUM_RANDOM / 2)
                wait_drained();
            p.sx = rand_coord();
            p.sy = rand_coord();
            p.sz = rand_coord();
            mode = $urandom_range(0, 19);
            if (mode < 2)
            begin
                // sky point at origin
                p.sx = '0;
                p.sy = '0;
                p.sz = '0;
            end
            if (mode == 2)
            begin
                // antenna on the sky point
                p.ax = p.sx;
                p.ay = p.sy;
                p.az = p.sz;
            end
            else if (mode == 3)
            begin
                p.ax = '0;
                p.ay = '0;
                p.az = '0;
            end
            else if (mode < 8)
            begin
                // array-sized antenna offsets around a far sky point
                p.ax = COORD_BITS'($urandom_range(0, 200000)) - COORD_BITS'(100000);
                p.ay = COORD_BITS'($urandom_range(0, 200000)) - COORD_BITS'(100000);
                p.az = COORD_BITS'($urandom_range(0, 2000)) - COORD_BITS'(1000);
            end
            else
            begin
                p.ax = rand_coord();
                p.ay = rand_coord();
                p.az = rand_coord();
            end
            push_request(p, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_delays.size() != 0)
            @(posedge clk);
        repeat (COORD_BITS + 20) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
